@@ hdl/gmvf_pkg.sv @@
`default_nettype none

package gmvf_pkg;

    // Field widths.
    localparam int MV_W       = 13;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID       = 1'b1;

    localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd1000;
    localparam logic [MV_W-1:0]       MAX_VALID_RST       = 13'd5000;

    // Operation codes.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Default window length.
    localparam int WINDOW_LEN_DEF = 15;

    // Largest voltage code, used to seed the sorting array.
    localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

    typedef struct packed {
        logic              opcode;
        logic              has_data;
        logic [MV_W-1:0]   cell_mv;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [MV_W-1:0] filtered_mv;
        logic            sample_taken;
        logic            primed;
    } out_item_t;

    // Control from the sequencer to the ranking array.
    typedef struct packed {
        logic clear;
        logic insert;
    } rank_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/gmvf_window_mem.sv @@
`default_nettype none

module gmvf_window_mem
    import gmvf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [$clog2(WINDOW_LEN)-1:0] waddr,
    input  wire logic [MV_W-1:0]               wdata,
    input  wire logic                          re,
    input  wire logic [$clog2(WINDOW_LEN)-1:0] raddr,
    output logic      [MV_W-1:0]               rdata
);

    logic [MV_W-1:0] mem [WINDOW_LEN];
    logic [MV_W-1:0] rdata_reg;

    // Sample window storage, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/gmvf_rank.sv @@
`default_nettype none

module gmvf_rank
    import gmvf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic            aclk,
    input  wire rank_ctrl_t      ctrl,
    input  wire logic [MV_W-1:0] din,
    output logic      [MV_W-1:0] median
);

    localparam int MID = WINDOW_LEN / 2;

    logic [MV_W-1:0] sorted_reg  [WINDOW_LEN];
    logic [MV_W-1:0] sorted_next [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] keep;
    logic [MV_W:0] mid_sum;

    // Insertion step: entries not above the new value stay, the rest move up one.
    always_comb begin
        for (int p = 0; p < WINDOW_LEN; p++) begin
            keep[p] = (sorted_reg[p] <= din);
        end
        for (int p = 0; p < WINDOW_LEN; p++) begin
            if (keep[p]) begin
                sorted_next[p] = sorted_reg[p];
            end else if (p > 0 && !keep[p-1]) begin
                sorted_next[p] = sorted_reg[p-1];
            end else begin
                sorted_next[p] = din;
            end
        end
    end

    // Seeded with the largest code so that no real value sorts above the seeds.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            for (int p = 0; p < WINDOW_LEN; p++) begin
                sorted_reg[p] <= MV_MAX;
            end
        end else if (ctrl.insert) begin
            sorted_reg <= sorted_next;
        end
    end

    // Middle value, or the floor of the mean of the two middle values.
    always_comb begin
        mid_sum = {1'b0, sorted_reg[MID]} + {1'b0, sorted_reg[(MID > 0) ? MID - 1 : 0]};
        if ((WINDOW_LEN % 2) != 0) begin
            median = sorted_reg[MID];
        end else begin
            median = mid_sum[MV_W:1];
        end
    end

endmodule

`default_nettype wire

@@ hdl/gated_median_voltage_filter_unit.sv @@
`default_nettype none

// Running median filter for the lowest cell voltage. Every input beat gives
// exactly one result beat. A clear beat or a rejected sample (no data, zero,
// above the limit, or too soon after the last sample) goes straight to the
// output state. The first good sample fills the window memory, one entry per
// cycle. A later good sample is written into the window memory and the whole
// window is read back through its single read port into a sorting array. A
// new beat is taken once the previous one has reached the output register.
module gated_median_voltage_filter_unit
    import gmvf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int CW = $clog2(WINDOW_LEN + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SORT,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [INTERVAL_W-1:0]   interval_reg;
    logic [MV_W-1:0]         max_mv_reg;
    logic [AW-1:0]           slot_reg;
    logic [TIME_W-1:0]       last_reg;
    logic [MV_W-1:0]         median_reg;
    logic                    primed_reg;
    logic                    taken_reg;
    logic [MV_W-1:0]         fill_mv_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    rd_pend_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic                    accept;
    logic                    good_sample;
    logic [TIME_W-1:0]       elapsed;
    logic                    on_time;
    logic                    cnt_open;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [MV_W-1:0]         mem_wdata;
    logic [MV_W-1:0]         mem_rdata;
    rank_ctrl_t              rank_ctrl;
    logic [MV_W-1:0]         rank_median;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sample qualification and wrapping elapsed time.
    assign good_sample = s_data.has_data && (s_data.cell_mv != '0)
                         && (s_data.cell_mv <= max_mv_reg);
    assign elapsed     = s_data.now_ms - last_reg;
    assign on_time     = (elapsed >= {{(TIME_W - INTERVAL_W){1'b0}}, interval_reg});
    assign cnt_open    = (cnt_reg < CW'(WINDOW_LEN));

    // Window memory write port: new sample on accept, or the priming fill sweep.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = s_data.cell_mv;
        if (state_reg == ST_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[AW-1:0];
            mem_wdata = fill_mv_reg;
        end else if (accept && s_data.opcode == OP_UPDATE && good_sample) begin
            if (!primed_reg) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
            end else if (on_time) begin
                mem_we    = 1'b1;
            end
        end
    end

    assign rank_ctrl.clear  = (state_reg == ST_IDLE);
    assign rank_ctrl.insert = rd_pend_reg;

    gmvf_window_mem #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    ((state_reg == ST_SORT) && cnt_open),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    gmvf_rank #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_rank (
        .aclk   (aclk),
        .ctrl   (rank_ctrl),
        .din    (mem_rdata),
        .median (rank_median)
    );

    // Sequencer, filter state, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            interval_reg <= SAMPLE_INTERVAL_RST;
            max_mv_reg   <= MAX_VALID_RST;
            slot_reg     <= '0;
            last_reg     <= '0;
            median_reg   <= '0;
            primed_reg   <= 1'b0;
            taken_reg    <= 1'b0;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SAMPLE_INTERVAL: interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                    REG_MAX_VALID:       max_mv_reg   <= cfg_wdata[MV_W-1:0];
                    default: ;
                endcase
            end

            // The output state reloads the register itself when it is free.
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_data.opcode == OP_CLEAR) begin
                            slot_reg   <= '0;
                            last_reg   <= '0;
                            median_reg <= '0;
                            primed_reg <= 1'b0;
                            taken_reg  <= 1'b0;
                            state_reg  <= ST_OUT;
                        end else if (good_sample && !primed_reg) begin
                            median_reg  <= s_data.cell_mv;
                            last_reg    <= s_data.now_ms;
                            slot_reg    <= '0;
                            primed_reg  <= 1'b1;
                            taken_reg   <= 1'b1;
                            fill_mv_reg <= s_data.cell_mv;
                            cnt_reg     <= CW'(1);
                            state_reg   <= ST_FILL;
                        end else if (good_sample && on_time) begin
                            last_reg  <= s_data.now_ms;
                            slot_reg  <= (slot_reg == AW'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
                            taken_reg <= 1'b1;
                            cnt_reg   <= '0;
                            state_reg <= ST_SORT;
                        end else begin
                            taken_reg <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_FILL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(WINDOW_LEN - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_SORT: begin
                    // Read sweep: registered read data feeds the sorting array.
                    rd_pend_reg <= cnt_open;
                    if (cnt_open) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else if (!rd_pend_reg) begin
                        median_reg <= rank_median;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_data_reg.filtered_mv   <= median_reg;
                        m_data_reg.sample_taken  <= taken_reg;
                        m_data_reg.primed        <= primed_reg;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_gated_median_voltage_filter_unit.sv @@
module tb_gated_median_voltage_filter_unit
    import gmvf_pkg::*;
;

    localparam int WIN_LEN     = WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int BACKLOG_AT  = 300;
    localparam int BACKLOG_LEN = 400;

    // Running median filter predictor plus the queue of results it expects.
    class median_scoreboard;
        logic [INTERVAL_W-1:0] interval_ms;
        logic [MV_W-1:0]       limit_mv;
        logic [MV_W-1:0]       win [WIN_LEN];
        int unsigned           slot;
        logic [TIME_W-1:0]     last_ms;
        logic [MV_W-1:0]       median;
        bit                    primed;
        out_item_t             expected_medians[$];
        int                    errors;
        int                    checked;
        int                    samples_taken;

        function new();
            interval_ms   = SAMPLE_INTERVAL_RST;
            limit_mv      = MAX_VALID_RST;
            errors        = 0;
            checked       = 0;
            samples_taken = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (win[i]) win[i] = '0;
            slot    = 0;
            last_ms = '0;
            median  = '0;
            primed  = 1'b0;
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction

        // Work out the result of one accepted input beat.
        function void predict_beat(in_item_t beat);
            out_item_t         res;
            logic [TIME_W-1:0] elapsed;
            logic [MV_W-1:0]   sorted [WIN_LEN];
            logic [MV_W-1:0]   v;
            int                j;
            bit                take;
            take    = 1'b0;
            elapsed = beat.now_ms - last_ms;
            if (beat.opcode == OP_CLEAR) begin
                clear_window();
            end else if (beat.has_data && beat.cell_mv != '0 && beat.cell_mv <= limit_mv) begin
                if (!primed) begin
                    // First good sample fills the whole window.
                    foreach (win[i]) win[i] = beat.cell_mv;
                    slot    = 0;
                    median  = beat.cell_mv;
                    last_ms = beat.now_ms;
                    primed  = 1'b1;
                    take    = 1'b1;
                end else if (elapsed >= 32'(interval_ms)) begin
                    last_ms   = beat.now_ms;
                    win[slot] = beat.cell_mv;
                    slot      = (slot + 1) % WIN_LEN;
                    // Insertion sort of the window, then take the middle.
                    sorted = win;
                    for (int i = 1; i < WIN_LEN; i++) begin
                        v = sorted[i];
                        j = i - 1;
                        while (j >= 0 && sorted[j] > v) begin
                            sorted[j + 1] = sorted[j];
                            j--;
                        end
                        sorted[j + 1] = v;
                    end
                    if (WIN_LEN % 2 != 0)
                        median = sorted[WIN_LEN / 2];
                    else
                        median = MV_W'((14'(sorted[WIN_LEN / 2 - 1]) +
                                        14'(sorted[WIN_LEN / 2])) / 2);
                    take = 1'b1;
                end
            end
            res.filtered_mv  = median;
            res.sample_taken = take;
            res.primed       = primed;
            expected_medians.push_back(res);
            if (take) samples_taken++;
        endfunction

        // Compare one result beat with the oldest expectation.
        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (expected_medians.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: filtered_mv=%0d taken=%0b primed=%0b",
                         $time, got.filtered_mv, got.sample_taken, got.primed);
                return;
            end
            want = expected_medians.pop_front();
            if (got.filtered_mv !== want.filtered_mv) begin
                errors++;
                $display("%0t: wrong filtered_mv: expected %0d, got %0d",
                         $time, want.filtered_mv, got.filtered_mv);
            end
            if (got.sample_taken !== want.sample_taken) begin
                errors++;
                $display("%0t: wrong sample_taken: expected %0b, got %0b",
                         $time, want.sample_taken, got.sample_taken);
            end
            if (got.primed !== want.primed) begin
                errors++;
                $display("%0t: wrong primed: expected %0b, got %0b",
                         $time, want.primed, got.primed);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    median_scoreboard  filter_sb;
    bit                idle_en;
    logic [TIME_W-1:0] clock_ms;
    int                beats_sent = 0;
    int                settings_applied = 1;
    int                cycle_count = 0;

    gated_median_voltage_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic in_item_t make_beat(logic op, logic hd, logic [MV_W-1:0] mv,
                                           logic [TIME_W-1:0] ms);
        in_item_t b;
        b.opcode   = op;
        b.has_data = hd;
        b.cell_mv  = mv;
        b.now_ms   = ms;
        return b;
    endfunction

    // Offer one input beat, with an optional gap first, and hold it until taken.
    task automatic send_beat(input in_item_t item);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        filter_sb.predict_beat(item);
        beats_sent++;
    endtask

    // Mostly well-paced samples with random voltages, plus clears, empty
    // beats, out-of-range voltages, early samples and time jumps.
    task automatic send_random_beats(input int count);
        in_item_t item;
        int       pick;
        int       gap_kind;
        int       ivl;
        int       lim;
        int       center;
        int       spread;
        ivl    = filter_sb.interval_ms;
        lim    = filter_sb.limit_mv;
        center = lim / 2 + 1;
        spread = lim / 8;
        repeat (count) begin
            pick     = $urandom_range(0, 99);
            gap_kind = $urandom_range(0, 9);
            if (gap_kind == 0)
                clock_ms = $urandom;
            else if (gap_kind < 3)
                clock_ms += (ivl == 0) ? $urandom_range(0, 3) : $urandom_range(0, ivl - 1);
            else if (gap_kind == 3)
                clock_ms += ivl;
            else
                clock_ms += ivl + $urandom_range(0, ivl / 2 + 3);
            item.opcode   = OP_UPDATE;
            item.has_data = 1'b1;
            item.now_ms   = clock_ms;
            item.cell_mv  = MV_W'($urandom);
            if (pick < 3) begin
                item.opcode = OP_CLEAR;
            end else if (pick < 8) begin
                item.has_data = 1'b0;
            end else if (pick < 11 || (pick < 14 && lim >= MV_MAX)) begin
                item.cell_mv = '0;
            end else if (pick < 14) begin
                item.cell_mv = MV_W'($urandom_range(lim + 1, MV_MAX));
            end else if (lim != 0) begin
                if (pick < 20)
                    item.cell_mv = (pick % 2 != 0) ? MV_W'(lim) : MV_W'(1);
                else if (pick < 60)
                    item.cell_mv = MV_W'($urandom_range(center - spread, center + spread));
                else
                    item.cell_mv = MV_W'($urandom_range(1, lim));
            end
            send_beat(item);
        end
    endtask

    // Drain the block, write both registers, then run random beats.
    task automatic run_phase(input logic [INTERVAL_W-1:0] ivl, input logic [MV_W-1:0] lim,
                             input int count, input bit with_idle);
        s_valid <= 1'b0;
        while (filter_sb.pending() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SAMPLE_INTERVAL;
        cfg_wdata <= CFG_DATA_W'(ivl);
        @(posedge aclk);
        cfg_index <= REG_MAX_VALID;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        filter_sb.interval_ms = ivl;
        filter_sb.limit_mv    = lim;
        settings_applied++;
        idle_en  = with_idle;
        clock_ms = $urandom;
        send_random_beats(count);
    endtask

    // Result side: check every beat, stall in short bursts, and once hold off
    // long enough for the block to back up into its input.
    initial begin : result_sink
        int hold_cycles;
        bit backlog_done;
        hold_cycles  = 0;
        backlog_done = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1)
                filter_sb.check_result(m_data);
            if (hold_cycles != 0)
                hold_cycles--;
            else if (!backlog_done && filter_sb.checked >= BACKLOG_AT) begin
                hold_cycles  = BACKLOG_LEN;
                backlog_done = 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0)
                hold_cycles = $urandom_range(1, 4);
            m_ready <= (hold_cycles == 0);
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timed out after %0d cycles", $time, cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [TIME_W-1:0] t0;
        filter_sb = new();
        idle_en   = 1'b1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SAMPLE_INTERVAL;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset register values, with time crossing the wrap.
        t0 = 32'hFFFF_FC00;
        send_beat(make_beat(OP_UPDATE, 1'b0, 13'd100, t0));
        send_beat(make_beat(OP_UPDATE, 1'b1, 13'd0, t0));
        send_beat(make_beat(OP_UPDATE, 1'b1, 13'd5001, t0));
        send_beat(make_beat(OP_CLEAR, 1'b1, MV_MAX, 32'hFFFF_FFFF));
        send_beat(make_beat(OP_UPDATE, 1'b1, 13'd5000, t0));
        send_beat(make_beat(OP_UPDATE, 1'b1, 13'd1, t0 + 999));
        send_beat(make_beat(OP_UPDATE, 1'b1, 13'd1, t0 + 1000));
        send_beat(make_beat(OP_UPDATE, 1'b0, 13'd7, t0 + 5000));
        send_beat(make_beat(OP_UPDATE, 1'b1, MV_MAX, t0 + 5000));
        // Enough samples to push the write slot around the whole ring.
        for (int i = 0; i < 15; i++)
            send_beat(make_beat(OP_UPDATE, 1'b1, 13'(2 + 7 * i), t0 + 2000 + 1000 * i));
        send_beat(make_beat(OP_CLEAR, 1'b0, 13'd0, 32'd0));

        clock_ms = $urandom;
        send_random_beats(200);
        run_phase(16'd0, MV_MAX, 200, 1'b1);
        run_phase(16'hFFFF, MV_MAX, 150, 1'b1);
        run_phase(16'd1, 13'd1, 120, 1'b0);
        run_phase(16'd0, 13'd0, 40, 1'b0);
        run_phase(16'($urandom_range(1, 3000)), 13'($urandom_range(1, 8191)), 200, 1'b1);
        run_phase(16'($urandom_range(1, 65535)), MV_MAX, 200, 1'b1);
        run_phase(SAMPLE_INTERVAL_RST, MAX_VALID_RST, 150, 1'b1);
        run_phase(16'($urandom_range(1, 2000)), 13'($urandom_range(100, 8191)), 200, 1'b0);
        s_valid <= 1'b0;

        // Let the last results drain, then watch for stray beats.
        while (filter_sb.pending() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
        if (filter_sb.pending() != 0) begin
            filter_sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, filter_sb.pending());
        end

        $display("Summary: %0d input beats under %0d register settings, %0d samples entered the window.",
                 beats_sent, settings_applied, filter_sb.samples_taken);
        $display("Summary: %0d result beats checked, including a %0d-cycle output backlog.",
                 filter_sb.checked, BACKLOG_LEN);
        if (filter_sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gmvf_pkg.sv
hdl/gmvf_window_mem.sv
hdl/gmvf_rank.sv
hdl/gated_median_voltage_filter_unit.sv
sim/tb_gated_median_voltage_filter_unit.sv
